### rtl/quadratic_least_squares_fit_macros.svh
// Assertion macros for the quadratic least-squares fit block.
// Included by the modules that check their own control logic.
`ifndef QUADRATIC_LEAST_SQUARES_FIT_MACROS_SVH
`define QUADRATIC_LEAST_SQUARES_FIT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define QLSF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("qlsf assertion failed");
// Implication checked in the cycle after the antecedent.
`define QLSF_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("qlsf assertion failed");
`else
`define QLSF_ASSERT(lbl, clk, rstn, prop)
`define QLSF_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

### rtl/qlsf_pkg.sv
// Package for the quadratic least-squares fit: widths, register-file map,
// solve programme, command and status types. Depends on nothing.
`default_nettype none

package qlsf_pkg;

  // Default parameter values.
  localparam int unsigned MAX_POINTS_DEF = 4096;
  localparam int unsigned COORD_BITS_DEF = 12;

  // Field and sum widths.
  localparam int unsigned XW     = 12;
  localparam int unsigned SX1_W  = 24;
  localparam int unsigned SX2_W  = 36;
  localparam int unsigned SX3_W  = 48;
  localparam int unsigned SX4_W  = 60;
  localparam int unsigned SY_W   = 24;
  localparam int unsigned SXY_W  = 36;
  localparam int unsigned SX2Y_W = 48;
  localparam int unsigned SY2_W  = 36;
  localparam int unsigned SSE_W  = 63;

  // Solve arithmetic: all intermediate values fit a 192-bit signed word.
  localparam int unsigned W         = 192;
  localparam int unsigned MUL_STEPS = 128;
  localparam int unsigned DIV_STEPS = W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Register file.
  localparam int unsigned RF_DEPTH = 32;
  localparam int unsigned RA_W     = $clog2(RF_DEPTH);
  typedef logic [RA_W-1:0] raddr_t;

  // Loaded sums.
  localparam raddr_t R_S1   = 5'd0;
  localparam raddr_t R_S2   = 5'd1;
  localparam raddr_t R_S3   = 5'd2;
  localparam raddr_t R_S4   = 5'd3;
  localparam raddr_t R_N    = 5'd4;
  localparam raddr_t R_T0   = 5'd5;
  localparam raddr_t R_T1   = 5'd6;
  localparam raddr_t R_T2   = 5'd7;
  localparam raddr_t R_Y2   = 5'd8;
  // Temporaries and results.
  localparam raddr_t R_P    = 5'd9;
  localparam raddr_t R_Q    = 5'd10;
  localparam raddr_t R_M0   = 5'd11;
  localparam raddr_t R_M1   = 5'd12;
  localparam raddr_t R_M2   = 5'd13;
  localparam raddr_t R_M1P  = 5'd14;
  localparam raddr_t R_M2P  = 5'd15;
  localparam raddr_t R_U2   = 5'd16;
  localparam raddr_t R_DET  = 5'd17;
  localparam raddr_t R_NUM0 = 5'd18;
  localparam raddr_t R_NUM1 = 5'd19;
  localparam raddr_t R_NUM2 = 5'd20;
  localparam raddr_t R_E    = 5'd21;

  // Output register selects for divisions.
  localparam raddr_t OUT_A = 5'd0;
  localparam raddr_t OUT_B = 5'd1;
  localparam raddr_t OUT_C = 5'd2;
  localparam raddr_t OUT_E = 5'd3;

  // Scaling shifts of the numerators.
  localparam logic [5:0] SH_A    = 6'd34;
  localparam logic [5:0] SH_B    = 6'd32;
  localparam logic [5:0] SH_C    = 6'd30;
  localparam logic [5:0] SH_NONE = 6'd0;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    raddr_t     dst;
    raddr_t     srca;
    raddr_t     srcb;
    logic [5:0] shift;
  } instr_t;

  localparam int unsigned PC_W     = 6;
  localparam int unsigned PROG_LEN = 49;
  localparam logic [PC_W-1:0] DET_PC  = 6'd13;
  localparam logic [PC_W-1:0] LAST_PC = 6'(PROG_LEN - 1);

  // Cramer's rule on the normal matrix [[S4,S3,S2],[S3,S2,S1],[S2,S1,N]]
  // with right-hand side [T2,T1,T0], then the residual numerator.
  function automatic instr_t prog_fetch(input logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      6'd0:  r = '{OP_MUL, R_P,    R_S2,   R_N,    SH_NONE};
      6'd1:  r = '{OP_MUL, R_Q,    R_S1,   R_S1,   SH_NONE};
      6'd2:  r = '{OP_SUB, R_M0,   R_P,    R_Q,    SH_NONE};
      6'd3:  r = '{OP_MUL, R_P,    R_S3,   R_N,    SH_NONE};
      6'd4:  r = '{OP_MUL, R_Q,    R_S1,   R_S2,   SH_NONE};
      6'd5:  r = '{OP_SUB, R_M1,   R_P,    R_Q,    SH_NONE};
      6'd6:  r = '{OP_MUL, R_P,    R_S3,   R_S1,   SH_NONE};
      6'd7:  r = '{OP_MUL, R_Q,    R_S2,   R_S2,   SH_NONE};
      6'd8:  r = '{OP_SUB, R_M2,   R_P,    R_Q,    SH_NONE};
      6'd9:  r = '{OP_MUL, R_P,    R_S4,   R_M0,   SH_NONE};
      6'd10: r = '{OP_MUL, R_Q,    R_S3,   R_M1,   SH_NONE};
      6'd11: r = '{OP_SUB, R_DET,  R_P,    R_Q,    SH_NONE};
      6'd12: r = '{OP_MUL, R_P,    R_S2,   R_M2,   SH_NONE};
      6'd13: r = '{OP_ADD, R_DET,  R_DET,  R_P,    SH_NONE};
      6'd14: r = '{OP_MUL, R_P,    R_T1,   R_N,    SH_NONE};
      6'd15: r = '{OP_MUL, R_Q,    R_S1,   R_T0,   SH_NONE};
      6'd16: r = '{OP_SUB, R_M1P,  R_P,    R_Q,    SH_NONE};
      6'd17: r = '{OP_MUL, R_P,    R_T1,   R_S1,   SH_NONE};
      6'd18: r = '{OP_MUL, R_Q,    R_S2,   R_T0,   SH_NONE};
      6'd19: r = '{OP_SUB, R_M2P,  R_P,    R_Q,    SH_NONE};
      6'd20: r = '{OP_MUL, R_P,    R_S3,   R_T0,   SH_NONE};
      6'd21: r = '{OP_MUL, R_Q,    R_T1,   R_S2,   SH_NONE};
      6'd22: r = '{OP_SUB, R_U2,   R_P,    R_Q,    SH_NONE};
      6'd23: r = '{OP_MUL, R_P,    R_T2,   R_M0,   SH_NONE};
      6'd24: r = '{OP_MUL, R_Q,    R_S3,   R_M1P,  SH_NONE};
      6'd25: r = '{OP_SUB, R_NUM0, R_P,    R_Q,    SH_NONE};
      6'd26: r = '{OP_MUL, R_P,    R_S2,   R_M2P,  SH_NONE};
      6'd27: r = '{OP_ADD, R_NUM0, R_NUM0, R_P,    SH_NONE};
      6'd28: r = '{OP_MUL, R_P,    R_S4,   R_M1P,  SH_NONE};
      6'd29: r = '{OP_MUL, R_Q,    R_T2,   R_M1,   SH_NONE};
      6'd30: r = '{OP_SUB, R_NUM1, R_P,    R_Q,    SH_NONE};
      6'd31: r = '{OP_MUL, R_P,    R_S2,   R_U2,   SH_NONE};
      6'd32: r = '{OP_ADD, R_NUM1, R_NUM1, R_P,    SH_NONE};
      6'd33: r = '{OP_MUL, R_P,    R_T2,   R_M2,   SH_NONE};
      6'd34: r = '{OP_MUL, R_Q,    R_S4,   R_M2P,  SH_NONE};
      6'd35: r = '{OP_SUB, R_NUM2, R_P,    R_Q,    SH_NONE};
      6'd36: r = '{OP_MUL, R_Q,    R_S3,   R_U2,   SH_NONE};
      6'd37: r = '{OP_SUB, R_NUM2, R_NUM2, R_Q,    SH_NONE};
      6'd38: r = '{OP_MUL, R_E,    R_Y2,   R_DET,  SH_NONE};
      6'd39: r = '{OP_MUL, R_P,    R_NUM0, R_T2,   SH_NONE};
      6'd40: r = '{OP_SUB, R_E,    R_E,    R_P,    SH_NONE};
      6'd41: r = '{OP_MUL, R_P,    R_NUM1, R_T1,   SH_NONE};
      6'd42: r = '{OP_SUB, R_E,    R_E,    R_P,    SH_NONE};
      6'd43: r = '{OP_MUL, R_P,    R_NUM2, R_T0,   SH_NONE};
      6'd44: r = '{OP_SUB, R_E,    R_E,    R_P,    SH_NONE};
      6'd45: r = '{OP_DIV, OUT_A,  R_NUM0, R_DET,  SH_A};
      6'd46: r = '{OP_DIV, OUT_B,  R_NUM1, R_DET,  SH_B};
      6'd47: r = '{OP_DIV, OUT_C,  R_NUM2, R_DET,  SH_C};
      6'd48: r = '{OP_DIV, OUT_E,  R_E,    R_DET,  SH_NONE};
      default: r = '{OP_ADD, R_P, R_P, R_P, SH_NONE};
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 64 bits.
  function automatic logic [63:0] sat64(input logic [W-1:0] v);
    logic [63:0] r;
    if (!v[W-1] && (|v[W-1:63])) begin
      r = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (v[W-1] && !(&v[W-1:63])) begin
      r = 64'h8000_0000_0000_0000;
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       load_wr;
    logic       capture_hold;
    logic       clear_acc;
    raddr_t     raddr_a;
    raddr_t     raddr_b;
    logic       op_start;
    alu_op_e    op;
    logic [5:0] shift;
    logic       step;
    logic       step_last;
    logic       res_wr;
    raddr_t     waddr;
    logic       out_wr;
    logic       sing_wr;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic det_zero;
    logic unit_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/qlsf_datapath.sv
// Datapath of the quadratic least-squares fit: power-sum accumulators,
// solve register file, shared multiply/divide unit and output registers.
// Depends on qlsf_pkg.
`default_nettype none

module qlsf_datapath #(
  parameter int unsigned MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = qlsf_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire qlsf_pkg::cmd_t        cmd_i,
  output qlsf_pkg::sts_t             sts_o,
  input  wire logic [11:0]           x_coord_i,
  input  wire logic [11:0]           y_coord_i,
  output logic signed [63:0]         coef_a_o,
  output logic signed [63:0]         coef_b_o,
  output logic signed [63:0]         coef_c_o,
  output logic [62:0]                residual_sse_o,
  output logic                       singular_flag_o,
  output logic                       overflow_flag_o
);
  import qlsf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  // Masked coordinates.
  logic [XW-1:0] x_m, y_m;
  assign x_m = XW'(x_coord_i[COORD_BITS-1:0]);
  assign y_m = XW'(y_coord_i[COORD_BITS-1:0]);

  // Point counter and capacity check.
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic             s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (cmd_i.clear_acc) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= 1'b0;
      if (cmd_i.accept) begin
        if (cnt_q < CNT_W'(MAX_POINTS)) begin
          cnt_q      <= cnt_q + 1'b1;
          s1_valid_q <= 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // First stage: squares and cross product.
  logic [XW-1:0]   s1_x_q, s1_y_q;
  logic [2*XW-1:0] s1_x2_q, s1_xy_q, s1_y2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_x_q  <= x_m;
      s1_y_q  <= y_m;
      s1_x2_q <= x_m * x_m;
      s1_xy_q <= x_m * y_m;
      s1_y2_q <= y_m * y_m;
    end
  end

  // Second stage: higher powers and accumulation.
  logic [3*XW-1:0] p_x3, p_x2y;
  logic [4*XW-1:0] p_x4;
  assign p_x3  = s1_x2_q * s1_x_q;
  assign p_x2y = s1_x2_q * s1_y_q;
  assign p_x4  = s1_x2_q * s1_x2_q;

  logic [SX1_W-1:0]  sum_x1_q;
  logic [SX2_W-1:0]  sum_x2_q;
  logic [SX3_W-1:0]  sum_x3_q;
  logic [SX4_W-1:0]  sum_x4_q;
  logic [SY_W-1:0]   sum_y_q;
  logic [SXY_W-1:0]  sum_xy_q;
  logic [SX2Y_W-1:0] sum_x2y_q;
  logic [SY2_W-1:0]  sum_y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x1_q  <= '0;
      sum_x2_q  <= '0;
      sum_x3_q  <= '0;
      sum_x4_q  <= '0;
      sum_y_q   <= '0;
      sum_xy_q  <= '0;
      sum_x2y_q <= '0;
      sum_y2_q  <= '0;
    end else if (cmd_i.clear_acc) begin
      sum_x1_q  <= '0;
      sum_x2_q  <= '0;
      sum_x3_q  <= '0;
      sum_x4_q  <= '0;
      sum_y_q   <= '0;
      sum_xy_q  <= '0;
      sum_x2y_q <= '0;
      sum_y2_q  <= '0;
    end else if (s1_valid_q) begin
      sum_x1_q  <= sum_x1_q + SX1_W'(s1_x_q);
      sum_x2_q  <= sum_x2_q + SX2_W'(s1_x2_q);
      sum_x3_q  <= sum_x3_q + SX3_W'(p_x3);
      sum_x4_q  <= sum_x4_q + SX4_W'(p_x4);
      sum_y_q   <= sum_y_q + SY_W'(s1_y_q);
      sum_xy_q  <= sum_xy_q + SXY_W'(s1_xy_q);
      sum_x2y_q <= sum_x2y_q + SX2Y_W'(p_x2y);
      sum_y2_q  <= sum_y2_q + SY2_W'(s1_y2_q);
    end
  end

  // Values kept for the result while the accumulators restart.
  logic [SY2_W-1:0] y2_hold_q;
  logic             ovf_hold_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_hold) begin
      y2_hold_q  <= sum_y2_q;
      ovf_hold_q <= ovf_q;
    end
  end

  // Selection of the sum that is loaded into the register file.
  logic [W-1:0] load_data;
  always_comb begin
    case (cmd_i.waddr)
      R_S1:    load_data = W'(sum_x1_q);
      R_S2:    load_data = W'(sum_x2_q);
      R_S3:    load_data = W'(sum_x3_q);
      R_S4:    load_data = W'(sum_x4_q);
      R_N:     load_data = W'(cnt_q);
      R_T0:    load_data = W'(sum_y_q);
      R_T1:    load_data = W'(sum_xy_q);
      R_T2:    load_data = W'(sum_x2y_q);
      R_Y2:    load_data = W'(sum_y2_q);
      default: load_data = '0;
    endcase
  end

  // Register file: one write port, two registered read ports.
  logic [W-1:0] rf_q [RF_DEPTH];
  logic [W-1:0] rda_q, rdb_q;
  logic [W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      rf_q[cmd_i.waddr] <= load_data;
    end else if (cmd_i.res_wr) begin
      rf_q[cmd_i.waddr] <= acc_q;
    end
    rda_q <= rf_q[cmd_i.raddr_a];
    rdb_q <= rf_q[cmd_i.raddr_b];
  end

  // Zero flag of the last result written back.
  logic zero_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
    end else if (cmd_i.res_wr) begin
      zero_q <= (acc_q == '0);
    end
  end

  // Operand preparation for a rounded division.
  logic [W-1:0] n_sh, n_abs, d_abs;
  assign n_sh  = rda_q << cmd_i.shift;
  assign n_abs = n_sh[W-1] ? (~n_sh + 1'b1) : n_sh;
  assign d_abs = rdb_q[W-1] ? (~rdb_q + 1'b1) : rdb_q;

  // Shared unit: add/subtract, shift-add multiply, restoring divide.
  logic [W-1:0]         ash_q;
  logic [MUL_STEPS-1:0] bsh_q;
  logic [W-1:0]         rem_q, nq_q, dv_q;
  logic                 neg_q;
  logic [W-1:0]         rem_sh;
  logic                 rem_ge;

  assign rem_sh = {rem_q[W-2:0], nq_q[W-1]};
  assign rem_ge = (rem_sh >= dv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_start) begin
      case (cmd_i.op)
        OP_ADD: acc_q <= rda_q + rdb_q;
        OP_SUB: acc_q <= rda_q - rdb_q;
        OP_MUL: begin
          acc_q <= '0;
          ash_q <= rda_q;
          bsh_q <= rdb_q[MUL_STEPS-1:0];
        end
        OP_DIV: begin
          rem_q <= '0;
          nq_q  <= {n_abs[W-2:0], 1'b0} + d_abs;
          dv_q  <= {d_abs[W-2:0], 1'b0};
          neg_q <= n_sh[W-1] ^ rdb_q[W-1];
        end
        default: acc_q <= acc_q;
      endcase
    end else if (cmd_i.step) begin
      case (cmd_i.op)
        OP_MUL: begin
          // The top multiplier bit carries negative weight.
          if (bsh_q[0]) begin
            acc_q <= cmd_i.step_last ? (acc_q - ash_q) : (acc_q + ash_q);
          end
          ash_q <= {ash_q[W-2:0], 1'b0};
          bsh_q <= {1'b0, bsh_q[MUL_STEPS-1:1]};
        end
        OP_DIV: begin
          rem_q <= rem_ge ? (rem_sh - dv_q) : rem_sh;
          nq_q  <= {nq_q[W-2:0], rem_ge};
        end
        default: acc_q <= acc_q;
      endcase
    end
  end

  // Signed, saturated quotient.
  logic [W-1:0] q_signed;
  logic [63:0]  q_sat;
  assign q_signed = neg_q ? (~nq_q + 1'b1) : nq_q;
  assign q_sat    = sat64(q_signed);

  // Output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sing_wr) begin
      coef_a_o        <= '0;
      coef_b_o        <= '0;
      coef_c_o        <= '0;
      residual_sse_o  <= SSE_W'(y2_hold_q);
      singular_flag_o <= 1'b1;
      overflow_flag_o <= ovf_hold_q;
    end else if (cmd_i.out_wr) begin
      case (cmd_i.waddr)
        OUT_A: begin
          coef_a_o        <= q_sat;
          singular_flag_o <= 1'b0;
          overflow_flag_o <= ovf_hold_q;
        end
        OUT_B: coef_b_o <= q_sat;
        OUT_C: coef_c_o <= q_sat;
        OUT_E: residual_sse_o <= q_signed[W-1] ? '0 : q_sat[SSE_W-1:0];
        default: coef_a_o <= coef_a_o;
      endcase
    end
  end

  assign sts_o.det_zero  = zero_q;
  assign sts_o.unit_busy = s1_valid_q;

endmodule

`default_nettype wire

### rtl/qlsf_ctrl.sv
// Controller of the quadratic least-squares fit: input handshake, sum
// loading, solve programme sequencing and output handshake.
// Depends on qlsf_pkg and the assertion macro header.
`default_nettype none
`include "quadratic_least_squares_fit_macros.svh"

module qlsf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           last_point_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output qlsf_pkg::cmd_t      cmd_o,
  input  wire qlsf_pkg::sts_t sts_i
);
  import qlsf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_LOAD,
    S_FETCH,
    S_START,
    S_RUN,
    S_WB,
    S_WAIT_OUT
  } state_e;

  state_e            state_q;
  logic [PC_W-1:0]   pc_q;
  logic [STEP_W-1:0] cnt_q;
  raddr_t            lidx_q;
  logic              out_valid_q;

  instr_t instr;
  logic   accept;
  logic   out_free;
  logic   last_step;

  assign instr     = prog_fetch(pc_q);
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = (instr.op == OP_MUL) ? (cnt_q == STEP_W'(MUL_STEPS - 1))
                                          : (cnt_q == STEP_W'(DIV_STEPS - 1));

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode.
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.op     = instr.op;
    cmd_o.shift  = instr.shift;
    case (state_q)
      S_LOAD: begin
        cmd_o.load_wr      = 1'b1;
        cmd_o.waddr        = lidx_q;
        cmd_o.capture_hold = (lidx_q == R_S1);
        cmd_o.clear_acc    = (lidx_q == R_Y2);
      end
      S_FETCH: begin
        cmd_o.raddr_a = instr.srca;
        cmd_o.raddr_b = instr.srcb;
      end
      S_START: cmd_o.op_start = 1'b1;
      S_RUN: begin
        cmd_o.step      = 1'b1;
        cmd_o.step_last = last_step;
      end
      S_WB: begin
        cmd_o.waddr  = instr.dst;
        cmd_o.out_wr = (instr.op == OP_DIV);
        cmd_o.res_wr = (instr.op != OP_DIV);
      end
      S_WAIT_OUT: cmd_o.sing_wr = out_free && sts_i.det_zero;
      default: cmd_o.accept = accept;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      lidx_q      <= R_S1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && last_point_i) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // The last point is summed during this cycle.
          if (!sts_i.unit_busy) begin
            lidx_q  <= R_S1;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          lidx_q <= lidx_q + 1'b1;
          if (lidx_q == R_Y2) begin
            pc_q    <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: state_q <= S_START;
        S_START: begin
          cnt_q <= '0;
          if (instr.op == OP_ADD || instr.op == OP_SUB) begin
            state_q <= S_WB;
          end else begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= S_WB;
          end
        end
        S_WB: begin
          pc_q <= pc_q + 1'b1;
          if (pc_q == DET_PC) begin
            state_q <= S_WAIT_OUT;
          end else if (pc_q == LAST_PC) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_FETCH;
          end
        end
        S_WAIT_OUT: begin
          // The output register must be free before it is rewritten.
          if (out_free) begin
            if (sts_i.det_zero) begin
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_FETCH;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencing.
  `QLSF_ASSERT_NEXT(a_last_stalls, clk_i, rst_ni, accept && last_point_i, in_stall_o)
  `QLSF_ASSERT(a_one_write, clk_i, rst_ni, $onehot0({cmd_o.load_wr, cmd_o.res_wr, cmd_o.out_wr, cmd_o.sing_wr}))
  `QLSF_ASSERT(a_out_free, clk_i, rst_ni, !(cmd_o.out_wr || cmd_o.sing_wr) || !out_valid_q || !out_stall_i)
  `QLSF_ASSERT(a_no_accept_solve, clk_i, rst_ni, !(cmd_o.accept && (cmd_o.step || cmd_o.load_wr)))

endmodule

`default_nettype wire

### rtl/quadratic_least_squares_fit.sv
// From the transfer of the last point, the result follows a drain, the loading of the sums,
// 28 multiplies, 17 add/subtract and 4 divides, and an output check; a singular system
// ends after the determinant, the drain does not wait for a last point beyond capacity,
// and the result is held back while an earlier result is still stalled at the output.
// Throughput: one point per cycle while a curve is summed; the input stalls during
// the solve, which runs on the shared bit-serial multiply/divide unit.
`default_nettype none

module quadratic_least_squares_fit #(
  parameter int unsigned MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = qlsf_pkg::COORD_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [11:0]   x_coord_i,
  input  wire logic [11:0]   y_coord_i,
  input  wire logic          last_point_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic signed [63:0] coef_a_o,
  output logic signed [63:0] coef_b_o,
  output logic signed [63:0] coef_c_o,
  output logic [62:0]        residual_sse_o,
  output logic               singular_flag_o,
  output logic               overflow_flag_o
);
  import qlsf_pkg::*;

  // Reset is asynchronous and active low; it clears all sums, the count and the
  // handshake state.
  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  qlsf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Sums, solve arithmetic and result registers.
  qlsf_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .coef_a_o        (coef_a_o),
    .coef_b_o        (coef_b_o),
    .coef_c_o        (coef_c_o),
    .residual_sse_o  (residual_sse_o),
    .singular_flag_o (singular_flag_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule

`default_nettype wire
